// ===== rtl/pjt_pkg.sv =====
// ----------------------------------------------------------------------------
// pjt_pkg: shared types and constants for the periodic job timer table
// Slot entry layout, result layout, item kind codes and interval unit scales.
// ----------------------------------------------------------------------------
package pjt_pkg;

  localparam int MAX_JOBS = 32;
  localparam int SLOT_W   = $clog2(MAX_JOBS);
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);
  localparam int JCNT_W   = 6;   // width of the job_count register

  localparam logic [31:0] RESET_INTERVAL = 32'd1000;
  localparam logic [21:0] MS_PER_S   = 22'd1000;
  localparam logic [21:0] MS_PER_MIN = 22'd60000;
  localparam logic [21:0] MS_PER_H   = 22'd3600000;

  // input item kinds
  localparam logic [2:0] KIND_TICK    = 3'd0;
  localparam logic [2:0] KIND_SET_IVL = 3'd1;
  localparam logic [2:0] KIND_SET_DIS = 3'd2;
  localparam logic [2:0] KIND_ARM     = 3'd3;
  localparam logic [2:0] KIND_QUERY   = 3'd4;

  // interval units
  localparam logic [1:0] UNIT_MS  = 2'd0;
  localparam logic [1:0] UNIT_S   = 2'd1;
  localparam logic [1:0] UNIT_MIN = 2'd2;
  localparam logic [1:0] UNIT_H   = 2'd3;

  // result kinds
  localparam logic RES_FIRE  = 1'b0;
  localparam logic RES_QUERY = 1'b1;

  typedef struct packed {
    logic [31:0] interval;
    logic [63:0] due;
    logic        disabled;
    logic [31:0] run;
  } entry_t;

  localparam entry_t RESET_ENTRY = '{interval: RESET_INTERVAL, due: 64'd0,
                                     disabled: 1'b0, run: 32'd0};

  typedef struct packed {
    logic        kind;
    logic [4:0]  job_index;
    logic [31:0] interval;
    logic [31:0] remaining;
    logic [31:0] run;
    logic        disabled;
    logic        last;
  } result_t;

  function automatic logic [21:0] unit_scale(input logic [1:0] unit);
    logic [21:0] s;
    unique case (unit)
      UNIT_MS:  s = 22'd1;
      UNIT_S:   s = MS_PER_S;
      UNIT_MIN: s = MS_PER_MIN;
      UNIT_H:   s = MS_PER_H;
      default:  s = 22'd1;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/pjt_tmem.sv =====
// ----------------------------------------------------------------------------
// pjt_tmem: job slot memory
// One-port-write, one-port-read synchronous store with a registered read.
// Per-slot valid bits cleared by reset; an unwritten slot reads as the reset
// entry, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module pjt_tmem
  import pjt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [SLOT_W-1:0] rd_addr,
  output entry_t            rd_entry,
  input  logic              wr_en,
  input  logic [SLOT_W-1:0] wr_addr,
  input  entry_t            wr_entry
);

  entry_t             mem [MAX_JOBS];
  logic [MAX_JOBS-1:0] valid;
  entry_t             rd_data;
  logic               rd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= valid[rd_addr];
      end
    end
  end

  assign rd_entry = rd_hit ? rd_data : RESET_ENTRY;

endmodule

// ===== rtl/periodic_job_timer_table_top.sv =====
// ----------------------------------------------------------------------------
// periodic_job_timer_table_top: table of periodic job timers
// Tick items fire due jobs and re-arm them; other items set intervals,
// disable marks, arm all jobs or query one job.
// ----------------------------------------------------------------------------
// Timing: one item at a time. A tick or arm-all item steps through accept,
// the first slot read, one step per active slot (n: job_count clamped to
// MAX_JOBS) reading the next slot as the current one is written back, and a
// flush releasing any parked final fire item. Set interval, set disable and
// query step through accept, read and execute; an unknown kind, a slot at or
// above n or a scan with n zero ends after accept and read. The slot memory's
// single read and write port sets the one-slot-per-cycle scan; a downstream
// stall holds it only when a fire item has nowhere to go: one fired result is
// parked until the next one (or the end of the scan) shows whether it carries
// tlast. The slot memory needs no clearing pass after reset; per slot valid
// bits make unwritten slots read as 1000 ms, due 0, enabled, count 0.
// job_count may be written at any time the block is idle.
// ----------------------------------------------------------------------------
module periodic_job_timer_table_top
  import pjt_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // configuration: job_count
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [5:0]   cfg_data,
  // input items
  input  logic         s_tvalid,
  output logic         s_tready,
  // [4:0] job, [36:5] amount, [38:37] unit, [39] disable_flag, [103:40] now_ms
  input  logic [103:0] s_tdata,
  // [2:0] kind
  input  logic [2:0]   s_tuser,
  // result items
  output logic         m_tvalid,
  input  logic         m_tready,
  // [4:0] job_index, [36:5] interval_out, [68:37] remaining_ms,
  // [100:69] run_count, [101] disabled_out, [103:102] zero
  output logic [103:0] m_tdata,
  // [0] result_kind
  output logic [0:0]   m_tuser,
  output logic         m_tlast
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_EXEC, S_FLUSH} state_t;

  state_t             state;
  logic [JCNT_W-1:0]  job_count;
  logic [CNT_W-1:0]   n_act;

  // latched item
  logic [2:0]         item_kind;
  logic [4:0]         item_job;
  logic [31:0]        item_amount;
  logic [1:0]         item_unit;
  logic               item_dis;
  logic [63:0]        item_now;

  logic [SLOT_W-1:0]  slot;
  logic [53:0]        prod;
  result_t            pend;
  logic               pend_valid;
  result_t            out_res;

  // memory interface
  logic               rd_en;
  logic [SLOT_W-1:0]  rd_addr;
  entry_t             cur;
  logic               wr_en;
  entry_t             wr_entry;

  // datapath
  logic               is_scan;
  logic               go_read;
  logic [SLOT_W-1:0]  start_slot;
  logic               is_due;
  logic [64:0]        due_sum;
  logic [63:0]        new_due;
  logic [31:0]        fire_rem;
  logic [64:0]        q_diff;
  logic [31:0]        q_rem;
  logic [31:0]        ivl_sat;
  logic               out_free;
  logic               out_load;
  logic               last_slot;
  logic               advance;
  logic               done;
  logic               fire_go;
  logic               q_go;
  result_t            fire_res;
  result_t            q_res;

  pjt_tmem u_tmem (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (cur),
    .wr_en    (wr_en),
    .wr_addr  (slot),
    .wr_entry (wr_entry)
  );

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign m_tdata   = {2'b00, out_res.disabled, out_res.run, out_res.remaining,
                      out_res.interval, out_res.job_index};
  assign m_tuser   = out_res.kind;
  assign m_tlast   = out_res.last;

  always_comb begin
    if (32'(job_count) > MAX_JOBS) begin
      n_act = CNT_W'(MAX_JOBS);
    end else begin
      n_act = CNT_W'(job_count);
    end
  end

  assign is_scan    = (item_kind == KIND_TICK) || (item_kind == KIND_ARM);
  assign start_slot = is_scan ? '0 : SLOT_W'(item_job);
  assign go_read    = is_scan ? (n_act != '0)
                    : (((item_kind == KIND_SET_IVL) || (item_kind == KIND_SET_DIS) ||
                        (item_kind == KIND_QUERY)) && (32'(item_job) < 32'(n_act)));
  assign last_slot  = ((CNT_W'(slot) + CNT_W'(1)) == n_act);
  assign out_free   = !m_tvalid || m_tready;

  // output register loads: parked fire pushed out, query answer, final fire
  assign out_load   = (fire_go && pend_valid) || q_go ||
                      ((state == S_FLUSH) && pend_valid && out_free);

  // re-arm: saturating add; the distance back to now is the interval unless
  // the sum saturated, in which case it is all-ones minus now
  assign is_due   = !cur.disabled && (item_now >= cur.due);
  assign due_sum  = {1'b0, item_now} + {33'd0, cur.interval};
  assign new_due  = due_sum[64] ? '1 : due_sum[63:0];
  assign fire_rem = due_sum[64] ? ~item_now[31:0] : cur.interval;

  assign q_diff   = {1'b0, cur.due} - {1'b0, item_now};
  assign q_rem    = q_diff[64] ? 32'd0 : q_diff[31:0];

  assign ivl_sat  = (prod[53:32] != '0) ? '1 : prod[31:0];

  always_comb begin
    fire_res = '{kind: RES_FIRE, job_index: 5'(slot), interval: cur.interval,
                 remaining: fire_rem, run: cur.run + 32'd1, disabled: 1'b0,
                 last: 1'b0};
    q_res    = '{kind: RES_QUERY, job_index: 5'(slot), interval: cur.interval,
                 remaining: q_rem, run: cur.run, disabled: cur.disabled,
                 last: 1'b1};
  end

  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = start_slot;
    wr_en    = 1'b0;
    wr_entry = cur;
    advance  = 1'b0;
    done     = 1'b0;
    fire_go  = 1'b0;
    q_go     = 1'b0;
    unique case (state)
      S_READ: begin
        rd_en = go_read;
      end
      S_EXEC: begin
        case (item_kind)
          KIND_TICK: begin
            if (is_due) begin
              if (!pend_valid || out_free) begin
                wr_en        = 1'b1;
                wr_entry.run = cur.run + 32'd1;
                wr_entry.due = new_due;
                fire_go      = 1'b1;
                advance      = 1'b1;
              end
            end else begin
              advance = 1'b1;
            end
          end
          KIND_ARM: begin
            wr_en        = 1'b1;
            wr_entry.due = new_due;
            advance      = 1'b1;
          end
          KIND_SET_IVL: begin
            wr_en             = (item_amount != 32'd0);
            wr_entry.interval = ivl_sat;
            done              = 1'b1;
          end
          KIND_SET_DIS: begin
            wr_en             = 1'b1;
            wr_entry.disabled = item_dis;
            done              = 1'b1;
          end
          KIND_QUERY: begin
            q_go = out_free;
            done = out_free;
          end
          default: begin
            done = 1'b1;
          end
        endcase
        // overlap: read the next slot while this one is written back
        if (advance && !last_slot) begin
          rd_en   = 1'b1;
          rd_addr = slot + SLOT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      job_count  <= '0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        job_count <= cfg_data;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            item_kind   <= s_tuser;
            item_job    <= s_tdata[4:0];
            item_amount <= s_tdata[36:5];
            item_unit   <= s_tdata[38:37];
            item_dis    <= s_tdata[39];
            item_now    <= s_tdata[103:40];
            state       <= S_READ;
          end
        end
        S_READ: begin
          prod <= 54'(item_amount) * 54'(unit_scale(item_unit));
          slot <= start_slot;
          state <= go_read ? S_EXEC : S_IDLE;
        end
        S_EXEC: begin
          if (fire_go) begin
            pend       <= fire_res;
            pend_valid <= 1'b1;
            if (pend_valid) begin
              out_res  <= pend;
            end
          end
          if (q_go) begin
            out_res  <= q_res;
          end
          if (advance) begin
            if (last_slot) begin
              state <= S_FLUSH;
            end else begin
              slot <= slot + SLOT_W'(1);
            end
          end
          if (done) begin
            state <= S_IDLE;
          end
        end
        S_FLUSH: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            // final fire item of the scan carries tlast (lowest bit)
            out_res      <= {pend[$bits(result_t)-1:1], 1'b1};
            pend_valid   <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a parked fire result never outlives its tick
  a_pend_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_valid)
    else $error("parked result left after item finished");

  // a query answer is always the only result of its item
  a_query_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == RES_QUERY)) |-> m_tlast)
    else $error("query result without tlast");

  // scan never walks past the active slots
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EXEC) && is_scan) |-> (32'(slot) < 32'(n_act)))
    else $error("scan slot out of range");

  // a fired job is parked on the next cycle
  a_fire_park: assert property (@(posedge clk) disable iff (rst)
    fire_go |=> pend_valid)
    else $error("fire result lost");

  // a fired result is only written back for a tick
  a_fire_kind: assert property (@(posedge clk) disable iff (rst)
    fire_go |-> (wr_en && (item_kind == KIND_TICK)))
    else $error("fire without write-back");

endmodule

// ===== sim/job_timer_checker.sv =====
// ----------------------------------------------------------------------------
// job_timer_checker: result checker for the periodic job timer table
// Keeps its own copy of the slot table, follows every accepted config write
// and input item, and compares each result item field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module job_timer_checker
  import pjt_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [5:0]   cfg_data,
  input  logic         s_tvalid,
  input  logic         s_tready,
  // [4:0] job, [36:5] amount, [38:37] unit, [39] disable_flag, [103:40] now_ms
  input  logic [103:0] s_tdata,
  // [2:0] kind
  input  logic [2:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  // [4:0] job_index, [36:5] interval_out, [68:37] remaining_ms,
  // [100:69] run_count, [101] disabled_out
  input  logic [103:0] m_tdata,
  // [0] result_kind
  input  logic [0:0]   m_tuser,
  input  logic         m_tlast,
  output int           errors,
  output int           outstanding
);

  logic [31:0] ivl_ms   [MAX_JOBS];
  logic [63:0] due_ms   [MAX_JOBS];
  logic        held     [MAX_JOBS];
  logic [31:0] fire_cnt [MAX_JOBS];
  logic [5:0]  job_count_reg;
  result_t     timer_results_q[$];
  result_t     want;

  function automatic logic [63:0] due_after(logic [63:0] now, logic [31:0] ivl);
    logic [64:0] sum;
    sum = {1'b0, now} + {33'd0, ivl};
    return sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum[63:0];
  endfunction

  function automatic logic [31:0] time_left(logic [63:0] due, logic [63:0] now);
    logic [63:0] diff;
    diff = due - now;
    return (due > now) ? diff[31:0] : 32'd0;
  endfunction

  function automatic logic [31:0] scaled_interval(logic [31:0] amount, logic [1:0] unit);
    logic [63:0] prod;
    logic [31:0] scale;
    case (unit)
      UNIT_S:   scale = {10'd0, MS_PER_S};
      UNIT_MIN: scale = {10'd0, MS_PER_MIN};
      UNIT_H:   scale = {10'd0, MS_PER_H};
      default:  scale = 32'd1;
    endcase
    prod = {32'd0, amount} * {32'd0, scale};
    return (prod[63:32] != 32'd0) ? 32'hFFFF_FFFF : prod[31:0];
  endfunction

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
    $display("%0t: mismatch in %s: got %0h, wanted %0h", $realtime, what, got, exp_val);
    errors++;
  endtask

  task automatic apply_timer_item(logic [2:0] kind_code, logic [103:0] data);
    logic [4:0]  job;
    logic [31:0] amount;
    logic [1:0]  unit;
    logic        dis;
    logic [63:0] now;
    int          n;
    result_t     r;
    result_t     fired[$];
    job    = data[4:0];
    amount = data[36:5];
    unit   = data[38:37];
    dis    = data[39];
    now    = data[103:40];
    n      = (job_count_reg > MAX_JOBS) ? MAX_JOBS : int'(job_count_reg);
    case (kind_code)
      KIND_TICK: begin
        for (int i = 0; i < n; i++) begin
          if (!held[i] && now >= due_ms[i]) begin
            fire_cnt[i]++;
            due_ms[i] = due_after(now, ivl_ms[i]);
            r = '{kind: RES_FIRE, job_index: 5'(i), interval: ivl_ms[i],
                  remaining: time_left(due_ms[i], now), run: fire_cnt[i],
                  disabled: held[i], last: 1'b0};
            fired.push_back(r);
          end
        end
        if (fired.size() > 0) fired[fired.size() - 1].last = 1'b1;
        foreach (fired[k]) timer_results_q.push_back(fired[k]);
      end
      KIND_ARM: begin
        for (int i = 0; i < n; i++) due_ms[i] = due_after(now, ivl_ms[i]);
      end
      KIND_SET_IVL: begin
        if (int'(job) < n && amount != 32'd0) ivl_ms[job] = scaled_interval(amount, unit);
      end
      KIND_SET_DIS: begin
        if (int'(job) < n) held[job] = dis;
      end
      KIND_QUERY: begin
        if (int'(job) < n) begin
          r = '{kind: RES_QUERY, job_index: job, interval: ivl_ms[job],
                remaining: time_left(due_ms[job], now), run: fire_cnt[job],
                disabled: held[job], last: 1'b1};
          timer_results_q.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_JOBS; i++) begin
        ivl_ms[i]   = RESET_INTERVAL;
        due_ms[i]   = 64'd0;
        held[i]     = 1'b0;
        fire_cnt[i] = 32'd0;
      end
      job_count_reg = 6'd0;
      timer_results_q.delete();
    end else begin
      // results drain before the new item's results are queued
      if (m_tvalid && m_tready) begin
        if (timer_results_q.size() == 0) begin
          flag_mismatch("result with nothing pending", {59'd0, m_tdata[4:0]}, 64'd0);
        end else begin
          want = timer_results_q.pop_front();
          if (m_tuser[0] != want.kind)
            flag_mismatch("result_kind", 64'(m_tuser[0]), 64'(want.kind));
          if (m_tdata[4:0] != want.job_index)
            flag_mismatch("job_index", 64'(m_tdata[4:0]), 64'(want.job_index));
          if (m_tdata[36:5] != want.interval)
            flag_mismatch("interval_out", 64'(m_tdata[36:5]), 64'(want.interval));
          if (m_tdata[68:37] != want.remaining)
            flag_mismatch("remaining_ms", 64'(m_tdata[68:37]), 64'(want.remaining));
          if (m_tdata[100:69] != want.run)
            flag_mismatch("run_count", 64'(m_tdata[100:69]), 64'(want.run));
          if (m_tdata[101] != want.disabled)
            flag_mismatch("disabled_out", 64'(m_tdata[101]), 64'(want.disabled));
          if (m_tlast != want.last)
            flag_mismatch("tlast", 64'(m_tlast), 64'(want.last));
        end
      end
      if (cfg_valid && cfg_ready) job_count_reg = cfg_data;
      if (s_tvalid && s_tready) apply_timer_item(s_tuser, s_tdata);
    end
    outstanding <= timer_results_q.size();
  end

endmodule

// ===== sim/periodic_job_timer_table_top_test.sv =====
// ----------------------------------------------------------------------------
// periodic_job_timer_table_top_test: testbench for the job timer table
// Directed items on the corner cases, then random phases under varying
// sender gaps and receiver stalls; a side checker scores every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module periodic_job_timer_table_top_test;
  import pjt_pkg::*;

  // kinds past the defined set, must be dropped silently
  localparam logic [2:0] KIND_BAD_FIRST = 3'd5;
  localparam logic [2:0] KIND_BAD_LAST  = 3'd7;

  localparam int RANDOM_PER_PHASE = 71;
  localparam int SETTLE_CYCLES    = 40;   // outlasts the widest scan
  localparam int LONG_HOLD_CYCLES = 300;

  logic         clk;
  logic         rst       = 1'b1;
  logic         cfg_valid = 1'b0;
  logic [5:0]   cfg_data  = '0;
  logic         s_tvalid  = 1'b0;
  logic [103:0] s_tdata   = '0;
  logic [2:0]   s_tuser   = '0;
  logic         m_tready  = 1'b0;
  logic         cfg_ready;
  logic         s_tready;
  logic         m_tvalid;
  logic [103:0] m_tdata;
  logic [0:0]   m_tuser;
  logic         m_tlast;

  int          fail_count;
  int          pending_results;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  bit          hold_request   = 1'b0;
  int          hold_left      = 0;
  int          slots_live     = 0;
  logic [63:0] wall_ms        = 64'd5000;

  periodic_job_timer_table_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  job_timer_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .errors      (fail_count),
    .outstanding (pending_results)
  );

  // 50 MHz
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: random stalls, plus a long hold-off on request so the
  // block backs up and has to stall its input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Tdata layout, lowest field first: job, amount, unit, disable_flag, now_ms.
  function automatic logic [103:0] pack_item(logic [4:0] job, logic [31:0] amount,
                                             logic [1:0] unit, logic dis,
                                             logic [63:0] now);
    return {now, dis, unit, amount, job};
  endfunction

  // Offer one item and return on the edge that accepts it. Valid stays up
  // afterwards; the next call either lowers it for a gap or replaces the item.
  task automatic offer_item(logic [2:0] kind_code, logic [103:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind_code;
    s_tdata  <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stop sending and wait for every queued result. The first edge lets the
  // checker's count take in an item accepted on the edge just past.
  task automatic quiesce();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    // items with no result may still be scanning
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called with the block idle.
  task automatic set_job_count(logic [5:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    slots_live = (value > MAX_JOBS) ? MAX_JOBS : int'(value);
  endtask

  // Ticks are the largest share, on a forward-moving clock with short
  // intervals so jobs fire often; the rest sets, queries, arms, and some noise.
  task automatic send_random_item();
    int          pick;
    logic [2:0]  kind_code;
    logic [4:0]  job;
    logic [31:0] amount;
    logic [1:0]  unit;
    logic        dis;
    logic [63:0] now;
    pick   = $urandom_range(99);
    job    = 5'($urandom);
    amount = $urandom;
    unit   = 2'($urandom);
    dis    = ($urandom_range(3) == 0);
    now    = {$urandom, $urandom};
    // mostly address live slots, sometimes any slot
    if (slots_live > 0 && $urandom_range(4) != 0) job = 5'($urandom_range(slots_live - 1));
    if (pick < 45) begin
      kind_code = KIND_TICK;
      wall_ms   = wall_ms + $urandom_range(300);
      now       = wall_ms;
    end else if (pick < 60) begin
      kind_code = KIND_SET_IVL;
      if ($urandom_range(3) != 0) begin
        amount = $urandom_range(400);
        unit   = UNIT_MS;
      end
    end else if (pick < 70) begin
      kind_code = KIND_SET_DIS;
    end else if (pick < 78) begin
      kind_code = KIND_ARM;
      now       = wall_ms;
    end else if (pick < 93) begin
      kind_code = KIND_QUERY;
      if ($urandom_range(4) != 0) now = wall_ms + $urandom_range(20);
    end else if (pick < 97) begin
      kind_code = 3'($urandom_range(KIND_BAD_LAST, KIND_BAD_FIRST));
    end else begin
      // tick at a wild time: may re-arm jobs far into the future
      kind_code = KIND_TICK;
    end
    offer_item(kind_code, pack_item(job, amount, unit, dis, now));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no active slots: everything is dropped
    set_job_count(6'd0);
    offer_item(KIND_TICK, pack_item(5'd0, 32'd0, UNIT_MS, 1'b0, 64'd0));
    offer_item(KIND_QUERY, pack_item(5'd0, 32'd0, UNIT_MS, 1'b0, 64'd0));
    offer_item(KIND_SET_DIS, pack_item(5'd0, 32'd0, UNIT_MS, 1'b1, 64'd0));
    quiesce();

    // directed corner cases on a full table
    set_job_count(6'd32);
    offer_item(KIND_QUERY, pack_item(5'd0, 32'd0, UNIT_MS, 1'b0, 64'd0));
    // everything due at zero: 32 fires from one item
    offer_item(KIND_TICK, pack_item('1, '1, UNIT_H, 1'b1, 64'd0));
    // zero count leaves the interval alone
    offer_item(KIND_SET_IVL, pack_item(5'd1, 32'd0, UNIT_H, 1'b0, 64'd0));
    offer_item(KIND_SET_IVL, pack_item(5'd1, 32'd5, UNIT_MS, 1'b0, 64'd0));
    // product saturates
    offer_item(KIND_SET_IVL, pack_item(5'd2, 32'hFFFF_FFFF, UNIT_H, 1'b0, 64'd0));
    offer_item(KIND_SET_IVL, pack_item(5'd3, 32'd3, UNIT_S, 1'b0, 64'd0));
    offer_item(KIND_SET_IVL, pack_item(5'd4, 32'd2, UNIT_MIN, 1'b0, 64'd0));
    offer_item(KIND_SET_IVL, pack_item(5'd5, 32'd1, UNIT_H, 1'b0, 64'd0));
    offer_item(KIND_SET_DIS, pack_item(5'd6, 32'd0, UNIT_MS, 1'b1, 64'd0));
    offer_item(KIND_QUERY, pack_item(5'd6, 32'd0, UNIT_MS, 1'b0, 64'd0));
    offer_item(KIND_ARM, pack_item(5'd0, 32'd0, UNIT_MS, 1'b0, 64'd100));
    // one ms short of the first due time: nothing fires
    offer_item(KIND_TICK, pack_item(5'd0, 32'd0, UNIT_MS, 1'b0, 64'd104));
    offer_item(KIND_TICK, pack_item(5'd0, 32'd0, UNIT_MS, 1'b0, 64'd105));
    // near the top of time: re-arm saturates
    offer_item(KIND_TICK, pack_item(5'd0, 32'd0, UNIT_MS, 1'b0, 64'hFFFF_FFFF_FFFF_FFF0));
    // remaining time wider than 32 bits gets truncated
    offer_item(KIND_QUERY, pack_item(5'd2, 32'd0, UNIT_MS, 1'b0, 64'd0));
    offer_item(KIND_QUERY, pack_item(5'd1, 32'd0, UNIT_MS, 1'b0, 64'hFFFF_FFFF_FFFF_FFF0));
    offer_item(KIND_BAD_FIRST, pack_item(5'd3, 32'd7, UNIT_S, 1'b1, 64'd0));
    offer_item(KIND_BAD_LAST, pack_item('1, '1, UNIT_H, 1'b1, '1));
    offer_item(KIND_SET_DIS, pack_item(5'd6, 32'd0, UNIT_MS, 1'b0, 64'd0));
    offer_item(KIND_ARM, pack_item(5'd0, 32'd0, UNIT_MS, 1'b0, '1));
    offer_item(KIND_QUERY, pack_item(5'd31, 32'd0, UNIT_MS, 1'b0, '1));
    offer_item(KIND_TICK, pack_item(5'd0, 32'd0, UNIT_MS, 1'b0, '1));
    quiesce();

    // random phases: no gaps, sender gaps, receiver stalls, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      case (phase)
        0: set_job_count(6'd63);                         // clamps to the table size
        1: set_job_count(6'($urandom_range(6, 1)));      // few slots: many misses
        2: set_job_count(6'($urandom_range(31, 7)));
        default: set_job_count(6'd32);
      endcase
      // pull every due time back near the running clock
      offer_item(KIND_ARM, pack_item(5'($urandom), $urandom, 2'($urandom), 1'($urandom),
                                     wall_ms));
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if (phase == 0 && i == 10) begin
          // starve the output while a big tick and more items keep coming
          hold_request = 1'b1;
          wall_ms      = wall_ms + 64'd2000;
          offer_item(KIND_TICK, pack_item(5'($urandom), $urandom, 2'($urandom),
                                          1'($urandom), wall_ms));
        end else begin
          send_random_item();
        end
      end
      quiesce();
    end

    if (fail_count == 0) begin
      $display("PASS periodic_job_timer_table_top");
    end else begin
      $display("FAIL periodic_job_timer_table_top");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("FAIL periodic_job_timer_table_top");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pjt_pkg.sv
rtl/pjt_tmem.sv
rtl/periodic_job_timer_table_top.sv
sim/job_timer_checker.sv
sim/periodic_job_timer_table_top_test.sv
